// ----- design/bvm_pkg.sv -----
package bvm_pkg;

    localparam int unsigned MV_W   = 16;
    localparam int unsigned PCT_W  = 7;
    localparam int unsigned GAIN_W = 20;
    localparam int unsigned HOLD_W = 40;
    localparam int unsigned CFG_W  = 40;
    localparam int unsigned IDX_W  = 3;
    // (mv - empty) * 100 fits in 23 bits
    localparam int unsigned NUM_W  = 23;

    localparam logic [MV_W-1:0]  MV_MAX   = 16'hFFFF;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;

    localparam logic [IDX_W-1:0] REG_GAIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_FULL   = 3'd1;
    localparam logic [IDX_W-1:0] REG_LOW    = 3'd2;
    localparam logic [IDX_W-1:0] REG_EMPTY  = 3'd3;
    localparam logic [IDX_W-1:0] REG_CHARGE = 3'd4;
    localparam logic [IDX_W-1:0] REG_HOLD   = 3'd5;

    localparam logic [GAIN_W-1:0] GAIN_RST   = 20'd212853;
    localparam logic [MV_W-1:0]   FULL_RST   = 16'd12400;
    localparam logic [MV_W-1:0]   LOW_RST    = 16'd10200;
    localparam logic [MV_W-1:0]   EMPTY_RST  = 16'd9000;
    localparam logic [MV_W-1:0]   CHARGE_RST = 16'd12000;
    localparam logic [HOLD_W-1:0] HOLD_RST   = 40'd300000000;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_SCALE = 6'b000100,
        ST_PREP  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [MV_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quo;
    } t_div_rsp;

endpackage

// ----- design/bvm_smp_if.sv -----
interface bvm_smp_if #(
    parameter int unsigned ADC_BITS  = 12,
    parameter int unsigned TIME_BITS = 48
);
    logic                 valid;
    logic                 ready;
    logic [ADC_BITS-1:0]  adc_raw;
    logic [TIME_BITS-1:0] now_us;

    modport source (output valid, output adc_raw, output now_us, input ready);
    modport sink   (input valid, input adc_raw, input now_us, output ready);
endinterface

// ----- design/bvm_res_if.sv -----
interface bvm_res_if;
    logic                        valid;
    logic                        ready;
    logic [bvm_pkg::MV_W-1:0]    vbat_mv;
    logic [bvm_pkg::PCT_W-1:0]   percent;
    logic                        charging;
    logic                        full_res;
    logic                        low_flag;

    modport source (output valid, output vbat_mv, output percent, output charging,
                    output full_res, output low_flag, input ready);
    modport sink   (input valid, input vbat_mv, input percent, input charging,
                    input full_res, input low_flag, output ready);
endinterface

// ----- design/bvm_div.sv -----
module bvm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bvm_pkg::t_div_req i_req,
    output bvm_pkg::t_div_rsp o_rsp
);

    localparam int unsigned CNT_W = $clog2(bvm_pkg::PCT_W);

    logic [bvm_pkg::NUM_W-1:0] r_rem;
    logic [bvm_pkg::NUM_W-1:0] r_dsh;
    logic [bvm_pkg::PCT_W-1:0] r_quo;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic                      w_ge;

    // one restoring step per cycle, shared compare and subtract
    assign w_ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_dsh <= bvm_pkg::NUM_W'(i_req.den) << (bvm_pkg::PCT_W - 1);
            r_cnt <= CNT_W'(bvm_pkg::PCT_W - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[bvm_pkg::PCT_W-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ----- design/battery_voltage_monitor_core.sv -----
// channel | dir | handshake      | payload
// i_smp   | in  | valid / ready  | adc_raw, now_us
// o_res   | out | valid / ready  | vbat_mv, percent, charging, full_res, low_flag
// i_cfg   | in  | write enable   | i_cfg_idx, i_cfg_wdata
//
// a word is accepted only once the previous one has gone through ST_MUL, ST_SCALE, ST_PREP and ST_DONE
// when percent is clamped, and also through ST_DIV, for the 7-step serial divider, when it is interpolated
// the result sits in an output register, so the next word is taken while it waits
// a word that finishes while the output register is still full waits in the core
// reset is synchronous and active low; it restores the register defaults and
// clears the full window
module battery_voltage_monitor_core #(
    parameter int unsigned ADC_BITS  = 12,
    parameter int unsigned TIME_BITS = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bvm_smp_if.sink                        i_smp,
    bvm_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [bvm_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [bvm_pkg::CFG_W-1:0]      i_cfg_wdata
);

    localparam int unsigned PROD_W = ADC_BITS + bvm_pkg::GAIN_W;
    localparam int unsigned CMP_W  = (TIME_BITS > bvm_pkg::HOLD_W) ? TIME_BITS
                                                                   : bvm_pkg::HOLD_W;

    bvm_pkg::t_state r_state, n_state;

    logic [bvm_pkg::GAIN_W-1:0] r_gain;
    logic [bvm_pkg::MV_W-1:0]   r_full, r_low, r_empty, r_charge;
    logic [bvm_pkg::HOLD_W-1:0] r_hold;

    logic [ADC_BITS-1:0]        r_adc;
    logic [TIME_BITS-1:0]       r_now;
    logic [PROD_W-1:0]          r_prod;
    logic [bvm_pkg::MV_W-1:0]   r_mv;
    logic [bvm_pkg::PCT_W-1:0]  r_pct;
    logic                       r_chg, r_fres, r_lowf;

    logic                       r_win_act;
    logic [TIME_BITS-1:0]       r_win_start;

    logic                       r_out_valid;
    logic [bvm_pkg::MV_W-1:0]   r_out_mv;
    logic [bvm_pkg::PCT_W-1:0]  r_out_pct;
    logic                       r_out_chg, r_out_fres, r_out_low;

    logic [PROD_W-1:0]          w_sh;
    logic [bvm_pkg::MV_W-1:0]   w_mv;
    logic                       w_at_full, w_above_empty, w_need_div;
    logic                       w_chg;
    logic [TIME_BITS-1:0]       w_start, w_elapsed;
    logic [bvm_pkg::MV_W-1:0]   w_diff;
    logic                       w_accept, w_load, w_out_free;

    bvm_pkg::t_div_req          w_req;
    bvm_pkg::t_div_rsp          w_rsp;

    bvm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign i_smp.ready = (r_state == bvm_pkg::ST_IDLE);
    assign w_accept    = i_smp.valid && i_smp.ready;
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_load      = (r_state == bvm_pkg::ST_DONE) && w_out_free;

    // saturate the Q16 product to millivolts
    assign w_sh = r_prod >> 16;
    assign w_mv = (w_sh > PROD_W'(bvm_pkg::MV_MAX)) ? bvm_pkg::MV_MAX
                                                    : w_sh[bvm_pkg::MV_W-1:0];

    assign w_at_full     = (r_mv >= r_full);
    assign w_above_empty = (r_mv > r_empty);
    assign w_need_div    = w_above_empty && !w_at_full;
    assign w_chg         = (r_mv > r_charge);

    assign w_start   = r_win_act ? r_win_start : r_now;
    assign w_elapsed = r_now - w_start;

    assign w_diff    = r_mv - r_empty;
    // times 100 as 64 + 32 + 4
    assign w_req.num = (bvm_pkg::NUM_W'(w_diff) << 6) + (bvm_pkg::NUM_W'(w_diff) << 5)
                     + (bvm_pkg::NUM_W'(w_diff) << 2);
    assign w_req.den   = r_full - r_empty;
    assign w_req.start = (r_state == bvm_pkg::ST_PREP) && w_need_div;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bvm_pkg::ST_IDLE:  if (w_accept) n_state = bvm_pkg::ST_MUL;
            bvm_pkg::ST_MUL:   n_state = bvm_pkg::ST_SCALE;
            bvm_pkg::ST_SCALE: n_state = bvm_pkg::ST_PREP;
            bvm_pkg::ST_PREP:  n_state = w_need_div ? bvm_pkg::ST_DIV : bvm_pkg::ST_DONE;
            bvm_pkg::ST_DIV:   if (w_rsp.done) n_state = bvm_pkg::ST_DONE;
            bvm_pkg::ST_DONE:  if (w_out_free) n_state = bvm_pkg::ST_IDLE;
            default:           n_state = bvm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bvm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_win_act   <= 1'b0;
            r_win_start <= '0;
            r_gain      <= bvm_pkg::GAIN_RST;
            r_full      <= bvm_pkg::FULL_RST;
            r_low       <= bvm_pkg::LOW_RST;
            r_empty     <= bvm_pkg::EMPTY_RST;
            r_charge    <= bvm_pkg::CHARGE_RST;
            r_hold      <= bvm_pkg::HOLD_RST;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == bvm_pkg::ST_PREP) begin
                r_win_act <= w_at_full;
                if (w_at_full && !r_win_act) begin
                    r_win_start <= r_now;
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bvm_pkg::REG_GAIN:   r_gain   <= i_cfg_wdata[bvm_pkg::GAIN_W-1:0];
                    bvm_pkg::REG_FULL:   r_full   <= i_cfg_wdata[bvm_pkg::MV_W-1:0];
                    bvm_pkg::REG_LOW:    r_low    <= i_cfg_wdata[bvm_pkg::MV_W-1:0];
                    bvm_pkg::REG_EMPTY:  r_empty  <= i_cfg_wdata[bvm_pkg::MV_W-1:0];
                    bvm_pkg::REG_CHARGE: r_charge <= i_cfg_wdata[bvm_pkg::MV_W-1:0];
                    bvm_pkg::REG_HOLD:   r_hold   <= i_cfg_wdata[bvm_pkg::HOLD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_adc <= i_smp.adc_raw;
            r_now <= i_smp.now_us;
        end
        if (r_state == bvm_pkg::ST_MUL) begin
            r_prod <= PROD_W'(r_adc) * PROD_W'(r_gain);
        end
        if (r_state == bvm_pkg::ST_SCALE) begin
            r_mv <= w_mv;
        end
        if (r_state == bvm_pkg::ST_PREP) begin
            r_chg  <= w_chg;
            r_lowf <= !w_chg && (r_mv < r_low);
            r_fres <= w_at_full && (CMP_W'(w_elapsed) >= CMP_W'(r_hold));
            r_pct  <= w_above_empty ? bvm_pkg::PCT_FULL : bvm_pkg::PCT_ZERO;
        end
        if (r_state == bvm_pkg::ST_DIV && w_rsp.done) begin
            r_pct <= w_rsp.quo;
        end
        if (w_load) begin
            r_out_mv   <= r_mv;
            r_out_pct  <= r_pct;
            r_out_chg  <= r_chg;
            r_out_fres <= r_fres;
            r_out_low  <= r_lowf;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.vbat_mv  = r_out_mv;
    assign o_res.percent  = r_out_pct;
    assign o_res.charging = r_out_chg;
    assign o_res.full_res = r_out_fres;
    assign o_res.low_flag = r_out_low;

endmodule

// ----- bench/battery_voltage_monitor_core_tb.sv -----
module battery_voltage_monitor_core_tb;

    localparam int unsigned ADC_W = 12;
    localparam int unsigned TS_W  = 48;

    localparam logic [ADC_W-1:0] ADC_TOP = 12'hFFF;

    // indexes past the last register, writes there must change nothing
    localparam logic [bvm_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [bvm_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int AN_EMPTY  = 0;
    localparam int AN_LOW    = 1;
    localparam int AN_CHARGE = 2;
    localparam int AN_FULL   = 3;

    localparam int SETTLE_CYCLES   = 30;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STUCK_LIMIT     = 2000;
    localparam int PRINT_LIMIT     = 50;

    typedef struct packed {
        logic [bvm_pkg::MV_W-1:0]  mv;
        logic [bvm_pkg::PCT_W-1:0] pct;
        logic                      chg;
        logic                      full;
        logic                      low;
    } t_reading;

    typedef struct {
        logic [ADC_W-1:0] adc;
        logic [TS_W-1:0]  ts;
        bit               typed;
        t_reading         want;
    } t_sample;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we;
    logic [bvm_pkg::IDX_W-1:0] i_cfg_idx;
    logic [bvm_pkg::CFG_W-1:0] i_cfg_wdata;

    bvm_smp_if #(.ADC_BITS(ADC_W), .TIME_BITS(TS_W)) smp_ch ();
    bvm_res_if res_ch ();

    battery_voltage_monitor_core #(
        .ADC_BITS  (ADC_W),
        .TIME_BITS (TS_W)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp       (smp_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register copies and full window, as the block should hold them
    logic [bvm_pkg::GAIN_W-1:0] gain_q16   = bvm_pkg::GAIN_RST;
    logic [bvm_pkg::MV_W-1:0]   lvl_full   = bvm_pkg::FULL_RST;
    logic [bvm_pkg::MV_W-1:0]   lvl_low    = bvm_pkg::LOW_RST;
    logic [bvm_pkg::MV_W-1:0]   lvl_empty  = bvm_pkg::EMPTY_RST;
    logic [bvm_pkg::MV_W-1:0]   lvl_charge = bvm_pkg::CHARGE_RST;
    logic [bvm_pkg::HOLD_W-1:0] hold_us    = bvm_pkg::HOLD_RST;
    logic                       win_open   = 1'b0;
    logic [TS_W-1:0]            win_start  = '0;

    t_sample  sample_fifo[$];
    t_reading pending_readings[$];

    logic [ADC_W-1:0] anchor [4];
    logic [TS_W-1:0]  stamp_us = '0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int stall_left = 0;
    int fail_count = 0;
    int stuck_cycles = 0;

    // default levels: 4095 counts reads 13300 mV, the hold runs across the stamp wrap
    t_sample directed_rows [18] = '{
        '{12'd0,    48'd0,              1'b1,
          '{16'd0,     bvm_pkg::PCT_ZERO, 1'b0, 1'b0, 1'b1}},
        '{12'd4095, 48'hFFFF_FFFF_FFFF, 1'b1,
          '{16'd13300, bvm_pkg::PCT_FULL, 1'b1, 1'b0, 1'b0}},
        '{12'd4095, 48'd299999998,      1'b0, '0},
        '{12'd4095, 48'd299999999,      1'b1,
          '{16'd13300, bvm_pkg::PCT_FULL, 1'b1, 1'b1, 1'b0}},
        '{12'd3000, 48'd5,              1'b0, '0},
        '{12'd4095, 48'd5000,           1'b0, '0},
        '{12'd4095, 48'd4999,           1'b0, '0},
        '{12'd2771, 48'd6000,           1'b0, '0},
        '{12'd2772, 48'd7000,           1'b0, '0},
        '{12'd3140, 48'd8000,           1'b0, '0},
        '{12'd3141, 48'd9000,           1'b0, '0},
        '{12'd3694, 48'd10000,          1'b0, '0},
        '{12'd3695, 48'd11000,          1'b0, '0},
        '{12'd3817, 48'd12000,          1'b0, '0},
        '{12'd3818, 48'd13000,          1'b0, '0},
        '{12'd3818, 48'd300013000,      1'b0, '0},
        '{12'hAAA,  48'hAAAA_AAAA_AAAA, 1'b0, '0},
        '{12'h555,  48'h5555_5555_5555, 1'b0, '0}
    };

    function automatic logic [bvm_pkg::MV_W-1:0] scale_mv(
        input logic [ADC_W-1:0] adc, input logic [bvm_pkg::GAIN_W-1:0] gain);
        longint unsigned prod;
        prod = adc;
        prod = (prod * gain) >> 16;
        return (prod > 64'd65535) ? bvm_pkg::MV_MAX : prod[bvm_pkg::MV_W-1:0];
    endfunction

    function automatic t_reading predict_reading(input logic [ADC_W-1:0] adc,
                                                 input logic [TS_W-1:0] ts);
        t_reading r;
        logic [TS_W-1:0] elapsed;
        longint unsigned span;
        r.mv = scale_mv(adc, gain_q16);
        r.chg = r.mv > lvl_charge;
        r.low = !r.chg && (r.mv < lvl_low);
        r.full = 1'b0;
        if (r.mv >= lvl_full) begin
            if (!win_open) begin
                win_open = 1'b1;
                win_start = ts;
            end
            // modulo difference, a stamp before the start reads as a long wait
            elapsed = ts - win_start;
            r.full = elapsed >= hold_us;
        end else begin
            win_open = 1'b0;
        end
        if (r.mv <= lvl_empty) begin
            r.pct = bvm_pkg::PCT_ZERO;
        end else if (r.mv >= lvl_full) begin
            r.pct = bvm_pkg::PCT_FULL;
        end else begin
            span = r.mv - lvl_empty;
            span = (span * 100) / (lvl_full - lvl_empty);
            r.pct = span[bvm_pkg::PCT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [ADC_W-1:0] anchor_for(input logic [bvm_pkg::MV_W-1:0] level);
        longint unsigned q;
        if (gain_q16 == '0) return ADC_W'($urandom_range(0, 4095));
        q = level;
        q = (q << 16) / gain_q16;
        return (q > 64'd4095) ? ADC_TOP : q[ADC_W-1:0];
    endfunction

    function automatic logic [bvm_pkg::CFG_W-1:0] with_junk(
        input logic [bvm_pkg::CFG_W-1:0] value, input int unsigned width);
        logic [63:0] junk;
        junk = {$urandom(), $urandom()};
        if (width >= bvm_pkg::CFG_W || $urandom_range(0, 1) == 0) return value;
        return value | bvm_pkg::CFG_W'(junk << width);
    endfunction

    function automatic int pick_gap();
        int unsigned roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) begin
            $display("%0t: mismatch on %s, got %0d, want %0d", $time, what, got, want);
        end
    endtask

    task automatic push_sample(input logic [ADC_W-1:0] adc, input logic [TS_W-1:0] ts);
        sample_fifo.push_back('{adc, ts, 1'b0, '0});
    endtask

    // called on a falling edge with the block idle
    task automatic write_reg(input logic [bvm_pkg::IDX_W-1:0] idx,
                             input logic [bvm_pkg::CFG_W-1:0] data);
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            bvm_pkg::REG_GAIN:   gain_q16 = data[bvm_pkg::GAIN_W-1:0];
            bvm_pkg::REG_FULL:   lvl_full = data[bvm_pkg::MV_W-1:0];
            bvm_pkg::REG_LOW:    lvl_low = data[bvm_pkg::MV_W-1:0];
            bvm_pkg::REG_EMPTY:  lvl_empty = data[bvm_pkg::MV_W-1:0];
            bvm_pkg::REG_CHARGE: lvl_charge = data[bvm_pkg::MV_W-1:0];
            bvm_pkg::REG_HOLD:   hold_us = data[bvm_pkg::HOLD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [bvm_pkg::GAIN_W-1:0] gain,
                              input logic [bvm_pkg::MV_W-1:0] full,
                              input logic [bvm_pkg::MV_W-1:0] low,
                              input logic [bvm_pkg::MV_W-1:0] empty,
                              input logic [bvm_pkg::MV_W-1:0] charge,
                              input logic [bvm_pkg::HOLD_W-1:0] hold);
        write_reg(bvm_pkg::REG_GAIN, with_junk(gain, bvm_pkg::GAIN_W));
        write_reg(bvm_pkg::REG_FULL, with_junk(full, bvm_pkg::MV_W));
        write_reg(bvm_pkg::REG_LOW, with_junk(low, bvm_pkg::MV_W));
        write_reg(bvm_pkg::REG_EMPTY, with_junk(empty, bvm_pkg::MV_W));
        write_reg(bvm_pkg::REG_CHARGE, with_junk(charge, bvm_pkg::MV_W));
        write_reg(bvm_pkg::REG_HOLD, hold);
        anchor[AN_EMPTY] = anchor_for(lvl_empty);
        anchor[AN_LOW] = anchor_for(lvl_low);
        anchor[AN_CHARGE] = anchor_for(lvl_charge);
        anchor[AN_FULL] = anchor_for(lvl_full);
    endtask

    task automatic random_config();
        logic [bvm_pkg::MV_W-1:0] lv[$];
        logic [bvm_pkg::GAIN_W-1:0] g;
        logic [bvm_pkg::HOLD_W-1:0] h;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) g = bvm_pkg::GAIN_W'($urandom_range(150000, 300000));
        else if (pick < 8) g = bvm_pkg::GAIN_W'($urandom());
        else g = bvm_pkg::GAIN_W'($urandom_range(600000, 1048575));
        // levels taken from real readings, some one above, so that samples land on or beside them
        repeat (4) begin
            lv.push_back(bvm_pkg::MV_W'(scale_mv(ADC_W'($urandom_range(0, 4095)), g)
                                        + $urandom_range(0, 1)));
        end
        lv.sort();
        if ($urandom_range(0, 4) == 0) lv.shuffle();
        pick = $urandom_range(0, 9);
        if (pick < 4) h = bvm_pkg::HOLD_W'($urandom_range(0, 2000));
        else if (pick < 8) h = bvm_pkg::HOLD_W'($urandom());
        else h = bvm_pkg::HOLD_W'({$urandom(), $urandom()});
        set_config(g, lv[3], lv[1], lv[0], lv[2], h);
    endtask

    task automatic feed_random(input int count);
        int made;
        int run_len;
        int j;
        int unsigned pick;
        bit exact;
        logic [ADC_W-1:0] a;
        logic [TS_W-1:0] base;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                // a stretch at or near full, stamps walking through the hold time
                run_len = $urandom_range(3, 8);
                exact = 1'($urandom_range(0, 1));
                base = stamp_us;
                for (j = 0; j < run_len; j++) begin
                    if (exact && j == 1) stamp_us = base + hold_us - 1;
                    else if (exact && j == 2) stamp_us = base + hold_us;
                    else if (j > 0)
                        stamp_us = stamp_us + hold_us / $urandom_range(2, 5) + $urandom_range(0, 3);
                    push_sample(ADC_W'($urandom_range(anchor[AN_FULL], 4095)), stamp_us);
                end
                made += run_len;
            end else if (pick < 70) begin
                a = anchor[$urandom_range(0, 3)];
                a = ADC_W'(a + $urandom_range(0, 4) - 2);
                stamp_us = stamp_us + hold_us / $urandom_range(3, 12) + $urandom_range(0, 50);
                push_sample(a, stamp_us);
                made++;
            end else if (pick < 90) begin
                stamp_us = stamp_us + $urandom_range(0, 100000);
                push_sample(ADC_W'($urandom_range(0, 4095)), stamp_us);
                made++;
            end else begin
                // stamp jumps anywhere, backwards included
                stamp_us = TS_W'({$urandom(), $urandom()});
                pick = $urandom_range(0, 2);
                a = (pick == 0) ? '0 : (pick == 1) ? ADC_TOP : ADC_W'($urandom());
                push_sample(a, stamp_us);
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        while (sample_fifo.size() != 0 || pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // sample side
    initial begin
        t_sample cur;
        t_reading pred;
        int gap;
        smp_ch.valid = 1'b0;
        smp_ch.adc_raw = '0;
        smp_ch.now_us = '0;
        @(negedge i_clk);
        forever begin
            if (sample_fifo.size() == 0) begin
                smp_ch.valid <= 1'b0;
                @(negedge i_clk);
            end else begin
                cur = sample_fifo[0];
                gap = pick_gap();
                if (gap > 0) begin
                    smp_ch.valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                smp_ch.valid <= 1'b1;
                smp_ch.adc_raw <= cur.adc;
                smp_ch.now_us <= cur.ts;
                do @(posedge i_clk); while (!smp_ch.ready);
                pred = predict_reading(cur.adc, cur.ts);
                pending_readings.push_back(cur.typed ? cur.want : pred);
                void'(sample_fifo.pop_front());
                @(negedge i_clk);
            end
        end
    end

    // result side
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("word with none expected, vbat_mv", res_ch.vbat_mv, 0);
            end else begin
                want = pending_readings.pop_front();
                if (res_ch.vbat_mv !== want.mv) report_mismatch("vbat_mv", res_ch.vbat_mv, want.mv);
                if (res_ch.percent !== want.pct) report_mismatch("percent", res_ch.percent, want.pct);
                if (res_ch.charging !== want.chg)
                    report_mismatch("charging", res_ch.charging, want.chg);
                if (res_ch.full_res !== want.full)
                    report_mismatch("full_res", res_ch.full_res, want.full);
                if (res_ch.low_flag !== want.low)
                    report_mismatch("low_flag", res_ch.low_flag, want.low);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stuck_cycles = 0;
        end else if (i_rst_n) begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
                $display("battery_voltage_monitor_core_tb failed");
                $finish;
            end
        end
    end

    initial begin
        int p;
        i_cfg_we = 1'b0;
        i_cfg_idx = bvm_pkg::REG_GAIN;
        i_cfg_wdata = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) sample_fifo.push_back(directed_rows[i]);
        wait_drained();

        // no gain and all levels at zero: every word reads full with no hold
        set_config('0, '0, '0, '0, '0, '0);
        feed_random(40);
        wait_drained();

        // every register at its ceiling
        set_config({bvm_pkg::GAIN_W{1'b1}}, bvm_pkg::MV_MAX, bvm_pkg::MV_MAX,
                   bvm_pkg::MV_MAX, bvm_pkg::MV_MAX, {bvm_pkg::HOLD_W{1'b1}});
        feed_random(40);
        wait_drained();

        // full level below empty, percent jumps straight from 0 to 100
        set_config(bvm_pkg::GAIN_RST, bvm_pkg::EMPTY_RST, bvm_pkg::LOW_RST,
                   bvm_pkg::CHARGE_RST, bvm_pkg::CHARGE_RST, 40'd1000);
        feed_random(60);
        wait_drained();

        set_config(bvm_pkg::GAIN_RST, bvm_pkg::FULL_RST, bvm_pkg::LOW_RST,
                   bvm_pkg::EMPTY_RST, bvm_pkg::CHARGE_RST, 40'd5000);
        write_reg(REG_SPARE_LO, bvm_pkg::CFG_W'({$urandom(), $urandom()}));
        write_reg(REG_SPARE_HI, bvm_pkg::CFG_W'({$urandom(), $urandom()}));
        feed_random(40);
        wait_drained();

        // receiver holds off while words keep coming, the core backs up
        quiet = 1'b1;
        hold_req = 1'b1;
        feed_random(80);
        wait_drained();
        quiet = 1'b0;

        for (p = 0; p < 9; p++) begin
            random_config();
            quiet = (p % 3 == 2);
            feed_random(150);
            wait_drained();
        end
        quiet = 1'b0;

        if (fail_count == 0 && pending_readings.size() == 0) begin
            $display("battery_voltage_monitor_core_tb passed");
        end else begin
            $display("battery_voltage_monitor_core_tb failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/bvm_pkg.sv
design/bvm_smp_if.sv
design/bvm_res_if.sv
design/bvm_div.sv
design/battery_voltage_monitor_core.sv
bench/battery_voltage_monitor_core_tb.sv
